### rtl/wohu_pkg.sv
// ----------------------------------------------------------------------------
// wohu_pkg
// Shared types and constants of the windowed overload hysteresis unit.
// ----------------------------------------------------------------------------
package wohu_pkg;

    // Number of usage metrics: cpu, memory, gpu, gpu memory.
    localparam int unsigned NMET   = 4;
    // Width of one usage sample or limit, tenths of a percent.
    localparam int unsigned SMP_W  = 10;
    // Width of the sample count field.
    localparam int unsigned CNT_W  = 3;
    // Configuration port widths.
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Metric indexes.
    localparam logic [1:0] MET_CPU  = 2'd0;
    localparam logic [1:0] MET_MEM  = 2'd1;
    localparam logic [1:0] MET_GPU  = 2'd2;
    localparam logic [1:0] MET_GPUM = 2'd3;

    // Address bit 2 picks the lower limit of a metric, bits 4:3 the metric.
    localparam logic LIM_UPPER = 1'b0;
    localparam logic LIM_LOWER = 1'b1;

    // Window status of one metric after this tick's update.
    typedef struct packed {
        logic filled;    // window holds at least one sample
        logic all_high;  // window non-empty and every sample high
        logic all_low;   // every sample low (an empty window counts)
    } t_met_stat;

    // One status word.
    typedef struct packed {
        logic       overloaded;
        logic [3:0] high_mask;
    } t_result;

endpackage

### rtl/wohu_met.sv
// ----------------------------------------------------------------------------
// wohu_met
// Window state of one metric: fill count and saturating high and low runs.
// ----------------------------------------------------------------------------
module wohu_met #(
    parameter int unsigned WIN = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_upd,
    input  logic [wohu_pkg::SMP_W-1:0] i_sample,
    input  logic [wohu_pkg::SMP_W-1:0] i_upper,
    input  logic [wohu_pkg::SMP_W-1:0] i_lower,
    output wohu_pkg::t_met_stat        o_stat
);
    import wohu_pkg::*;

    localparam int unsigned CW  = $clog2(WIN + 1);
    localparam logic [CW-1:0] CAP = CW'(WIN);

    logic [CW-1:0] r_fill, r_high, r_low;
    logic [CW-1:0] n_fill, n_high, n_low;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v >= CAP) ? CAP : v + CW'(1);
    endfunction

    always_comb begin
        n_fill = r_fill;
        n_high = r_high;
        n_low  = r_low;
        if (i_upd) begin
            n_fill = sat_inc(r_fill);
            n_high = (i_sample >= i_upper) ? sat_inc(r_high) : '0;
            n_low  = (i_sample <= i_lower) ? sat_inc(r_low) : '0;
        end
    end

    // Status reflects the window as it stands after this tick.
    assign o_stat.filled   = (n_fill != '0);
    assign o_stat.all_high = (n_fill != '0) && (n_high >= n_fill);
    assign o_stat.all_low  = (n_low >= n_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_high <= '0;
            r_low  <= '0;
        end else begin
            r_fill <= n_fill;
            r_high <= n_high;
            r_low  <= n_low;
        end
    end

endmodule

### rtl/wohu_obuf.sv
// ----------------------------------------------------------------------------
// wohu_obuf
// Output register with one skid entry for status words.
// ----------------------------------------------------------------------------
module wohu_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wohu_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_valid,
    output wohu_pkg::t_result o_res,
    output logic              o_skid_full
);
    import wohu_pkg::*;

    logic    r_vld, r_sk_vld;
    t_result r_head, r_skid;
    logic    pop;

    assign pop = r_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_sk_vld <= 1'b0;
        end else begin
            if (i_push) begin
                if (!r_vld || (pop && !r_sk_vld)) begin
                    r_vld <= 1'b1;
                end else if (pop) begin
                    r_sk_vld <= 1'b1;
                end else begin
                    r_sk_vld <= 1'b1;
                end
            end else if (pop) begin
                if (r_sk_vld) begin
                    r_sk_vld <= 1'b0;
                end else begin
                    r_vld <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_vld || (pop && !r_sk_vld)) begin
                r_head <= i_res;
            end else if (pop) begin
                r_head <= r_skid;
                r_skid <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end else if (pop && r_sk_vld) begin
            r_head <= r_skid;
        end
    end

    assign o_valid     = r_vld;
    assign o_res       = r_head;
    assign o_skid_full = r_sk_vld;

endmodule

### rtl/windowed_overload_hysteresis_unit.sv
// ----------------------------------------------------------------------------
// windowed_overload_hysteresis_unit
// Windowed overload detector with hysteresis over four usage metrics.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Word
//   --------  ---------  -----------------  -----------------------------------
//   input     in         i_valid / o_stall  four samples and a sample count
//   output    out        o_valid / i_stall  overloaded flag and high mask
//   config    in         APB write / read   eight 10-bit limits, 4-byte stride
//
//   One word is accepted per cycle when no stall is raised.
//   A status word reaches o_valid by way of the input register, one update
//   pass, then the output register; a full skid entry can hold it back.
//   Reset is synchronous, active low: windows empty, regular state, limits
//   at 900 (upper) and 700 (lower).
//   The output register has one skid entry behind it; o_stall rises only when
//   both hold a word and the input register is full.
//
// Operation: each accepted word is first captured in an input register. Once
// the skid is free, the first samples_valid metric windows are updated (fill
// count, run of high samples, run of low samples, each saturating at the window
// length), and the status check runs on the updated windows. In the regular
// state, when every window holds a sample and at least one window is entirely
// high, the block enters overload and sends a word with the mask of windows
// that are entirely high. In overload, once every window is entirely low (an
// empty window counts as low), the block returns to regular and sends a word
// with a zero mask. Ticks with no samples still run the check.
// ----------------------------------------------------------------------------
module windowed_overload_hysteresis_unit #(
    parameter int unsigned CPU_WINDOW  = 8,
    parameter int unsigned MEM_WINDOW  = 8,
    parameter int unsigned GPU_WINDOW  = 8,
    parameter int unsigned GPUM_WINDOW = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [wohu_pkg::SMP_W-1:0]  i_cpu_sample,
    input  logic [wohu_pkg::SMP_W-1:0]  i_mem_sample,
    input  logic [wohu_pkg::SMP_W-1:0]  i_gpu_sample,
    input  logic [wohu_pkg::SMP_W-1:0]  i_gpum_sample,
    input  logic [wohu_pkg::CNT_W-1:0]  i_samples_valid,
    // Output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_overloaded,
    output logic [3:0]                  o_high_mask,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wohu_pkg::ADDR_W-1:0] paddr,
    input  logic [wohu_pkg::DATA_W-1:0] pwdata,
    output logic [wohu_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import wohu_pkg::*;

    localparam int unsigned WIN_LEN [NMET] = '{CPU_WINDOW, MEM_WINDOW,
                                               GPU_WINDOW, GPUM_WINDOW};

    // ------------------------------------------------------------------
    // Configuration registers. Address bits 4:3 select the metric and
    // bit 2 the lower limit; the byte offset bits are ignored.
    // ------------------------------------------------------------------
    logic [SMP_W-1:0] r_upper [NMET];
    logic [SMP_W-1:0] r_lower [NMET];
    logic             cfg_wr;
    logic [1:0]       cfg_met;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_met = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < NMET; m++) begin
                r_upper[m] <= SMP_W'(900);
                r_lower[m] <= SMP_W'(700);
            end
        end else if (cfg_wr) begin
            if (paddr[2] == LIM_LOWER) begin
                r_lower[cfg_met] <= pwdata[SMP_W-1:0];
            end else begin
                r_upper[cfg_met] <= pwdata[SMP_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == LIM_UPPER) begin
            prdata = DATA_W'(r_upper[cfg_met]);
        end else begin
            prdata = DATA_W'(r_lower[cfg_met]);
        end
    end

    // ------------------------------------------------------------------
    // Input register. It empties whenever the update pass can place a
    // status word, which only the skid entry being full can block.
    // ------------------------------------------------------------------
    logic             r_in_vld;
    logic [SMP_W-1:0] r_smp [NMET];
    logic [CNT_W-1:0] r_cnt;
    logic             skid_full;
    logic             fire;
    logic             in_acc;

    assign fire    = r_in_vld && !skid_full;
    assign o_stall = r_in_vld && skid_full;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_smp[MET_CPU]  <= i_cpu_sample;
            r_smp[MET_MEM]  <= i_mem_sample;
            r_smp[MET_GPU]  <= i_gpu_sample;
            r_smp[MET_GPUM] <= i_gpum_sample;
            r_cnt           <= i_samples_valid;
        end
    end

    // ------------------------------------------------------------------
    // Metric windows. A count above four reaches every metric, which is
    // the same as four.
    // ------------------------------------------------------------------
    t_met_stat stat [NMET];

    for (genvar g = 0; g < NMET; g++) begin : g_met
        wohu_met #(
            .WIN (WIN_LEN[g])
        ) u_met (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_upd    (fire && (r_cnt > CNT_W'(g))),
            .i_sample (r_smp[g]),
            .i_upper  (r_upper[g]),
            .i_lower  (r_lower[g]),
            .o_stat   (stat[g])
        );
    end

    // ------------------------------------------------------------------
    // Hysteresis state and status word.
    // ------------------------------------------------------------------
    logic       r_ovl;
    logic [3:0] mask;
    logic       all_filled;
    logic       all_low;
    logic       go_ovl;
    logic       go_reg;
    t_result    res;

    always_comb begin
        all_filled = 1'b1;
        all_low    = 1'b1;
        for (int m = 0; m < NMET; m++) begin
            mask[m] = stat[m].all_high;
            if (!stat[m].filled) begin
                all_filled = 1'b0;
            end
            if (!stat[m].all_low) begin
                all_low = 1'b0;
            end
        end
    end

    assign go_ovl = fire && !r_ovl && all_filled && (mask != 4'd0);
    assign go_reg = fire && r_ovl && all_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovl <= 1'b0;
        end else if (go_ovl) begin
            r_ovl <= 1'b1;
        end else if (go_reg) begin
            r_ovl <= 1'b0;
        end
    end

    assign res.overloaded = go_ovl;
    assign res.high_mask  = go_ovl ? mask : 4'd0;

    t_result out_res;

    wohu_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (go_ovl || go_reg),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_res       (out_res),
        .o_skid_full (skid_full)
    );

    assign o_overloaded = out_res.overloaded;
    assign o_high_mask  = out_res.high_mask;

endmodule

### rtl/wohu_chk.sv
// ----------------------------------------------------------------------------
// wohu_chk
// Port-level checks of the windowed overload hysteresis unit.
// ----------------------------------------------------------------------------
module wohu_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_overloaded,
    input logic [3:0] o_high_mask,
    input logic       pready
);

    // A word held under stall keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_overloaded) && $stable(o_high_mask))
        else $error("status word changed while stalled");

    // A return to regular never carries a mask.
    a_reg_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_overloaded |-> o_high_mask == 4'd0)
        else $error("return to regular with nonzero mask");

    // Overload is entered only because some window is entirely high.
    a_ovl_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overloaded |-> o_high_mask != 4'd0)
        else $error("overload entered with empty mask");

    // Reset leaves no word on the output.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // The configuration port never waits.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind windowed_overload_hysteresis_unit wohu_chk u_wohu_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_overloaded (o_overloaded),
    .o_high_mask  (o_high_mask),
    .pready       (pready)
);

### tb/wohu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wohu_checker
// Status predictor and scoreboard for the windowed overload hysteresis unit.
// It follows every accepted sample word and every limit write, and predicts
// the overload transitions. It then compares each status word that leaves
// the block with the oldest prediction.
// ----------------------------------------------------------------------------
module wohu_checker #(
    parameter int unsigned CPU_WINDOW  = 8,
    parameter int unsigned MEM_WINDOW  = 8,
    parameter int unsigned GPU_WINDOW  = 8,
    parameter int unsigned GPUM_WINDOW = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input channel of the block
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [wohu_pkg::SMP_W-1:0]  i_cpu_sample,
    input  logic [wohu_pkg::SMP_W-1:0]  i_mem_sample,
    input  logic [wohu_pkg::SMP_W-1:0]  i_gpu_sample,
    input  logic [wohu_pkg::SMP_W-1:0]  i_gpum_sample,
    input  logic [wohu_pkg::CNT_W-1:0]  i_samples_valid,
    // Output channel of the block
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic                        i_overloaded,
    input  logic [3:0]                  i_high_mask,
    // Configuration port writes
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [wohu_pkg::ADDR_W-1:0] i_paddr,
    input  logic [wohu_pkg::DATA_W-1:0] i_pwdata,
    input  logic                        i_pready,
    // Results for the testbench top
    output int unsigned                 o_mismatches,
    output int unsigned                 o_pending,
    output int unsigned                 o_words_in,
    output int unsigned                 o_words_out
);
    import wohu_pkg::*;

    localparam int unsigned MAX_REPORTS = 10;
    localparam logic [SMP_W-1:0] RST_UPPER = 10'd900;
    localparam logic [SMP_W-1:0] RST_LOWER = 10'd700;
    // Expected status words are held in a small circular buffer.
    localparam int unsigned Q_AW    = 4;
    localparam int unsigned Q_DEPTH = 1 << Q_AW;

    int unsigned      win_len   [NMET];
    logic [SMP_W-1:0] upper_lim [NMET];
    logic [SMP_W-1:0] lower_lim [NMET];
    int unsigned      fill_cnt  [NMET];
    int unsigned      high_run  [NMET];
    int unsigned      low_run   [NMET];
    logic             in_overload;
    t_result          exp_mem   [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr;
    logic [Q_AW-1:0]  rd_ptr;
    int unsigned      exp_count;

    initial begin
        win_len[MET_CPU]  = CPU_WINDOW;
        win_len[MET_MEM]  = MEM_WINDOW;
        win_len[MET_GPU]  = GPU_WINDOW;
        win_len[MET_GPUM] = GPUM_WINDOW;
    end

    function automatic int unsigned sat_step(input int unsigned v, input int unsigned cap);
        return (v >= cap) ? cap : v + 1;
    endfunction

    // Pushes one tick into the windows and returns 1 when the state changes.
    function automatic bit predict_status(input logic [NMET-1:0][SMP_W-1:0] smp,
                                          input logic [CNT_W-1:0] cnt,
                                          output t_result word);
        int unsigned n;
        logic [3:0]  mask;
        bit          all_filled;
        bit          all_low;
        n = (cnt > NMET) ? NMET : cnt;
        for (int m = 0; m < n; m++) begin
            fill_cnt[m] = sat_step(fill_cnt[m], win_len[m]);
            high_run[m] = (smp[m] >= upper_lim[m]) ? sat_step(high_run[m], win_len[m]) : 0;
            low_run[m]  = (smp[m] <= lower_lim[m]) ? sat_step(low_run[m], win_len[m]) : 0;
        end
        mask       = '0;
        all_filled = 1'b1;
        all_low    = 1'b1;
        for (int m = 0; m < NMET; m++) begin
            if (fill_cnt[m] == 0)
                all_filled = 1'b0;
            else if (high_run[m] >= fill_cnt[m])
                mask[m] = 1'b1;
            if (low_run[m] < fill_cnt[m])
                all_low = 1'b0;
        end
        word = '0;
        if (!in_overload) begin
            if (all_filled && mask != 4'd0) begin
                in_overload     = 1'b1;
                word.overloaded = 1'b1;
                word.high_mask  = mask;
                return 1'b1;
            end
        end else if (all_low) begin
            in_overload = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input t_result exp_w, input t_result act_w);
        if (o_mismatches < MAX_REPORTS)
            $display("%0t: mismatch: expected ovl=%0b mask=%b, actual ovl=%0b mask=%b",
                     $realtime, exp_w.overloaded, exp_w.high_mask,
                     act_w.overloaded, act_w.high_mask);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result seen;
        if (!i_rst_n) begin
            for (int m = 0; m < NMET; m++) begin
                upper_lim[m] = RST_UPPER;
                lower_lim[m] = RST_LOWER;
                fill_cnt[m]  = 0;
                high_run[m]  = 0;
                low_run[m]   = 0;
            end
            in_overload  = 1'b0;
            wr_ptr       = '0;
            rd_ptr       = '0;
            exp_count    = 0;
            o_mismatches = 0;
            o_words_in   = 0;
            o_words_out  = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == LIM_UPPER)
                    upper_lim[i_paddr[4:3]] = i_pwdata[SMP_W-1:0];
                else
                    lower_lim[i_paddr[4:3]] = i_pwdata[SMP_W-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                o_words_in++;
                if (predict_status({i_gpum_sample, i_gpu_sample, i_mem_sample,
                                    i_cpu_sample}, i_samples_valid, want)) begin
                    if (exp_count < Q_DEPTH) begin
                        exp_mem[wr_ptr] = want;
                        wr_ptr          = wr_ptr + Q_AW'(1);
                        exp_count++;
                    end else begin
                        if (o_mismatches < MAX_REPORTS)
                            $display("%0t: more than %0d status words outstanding",
                                     $realtime, Q_DEPTH);
                        o_mismatches++;
                    end
                end
            end
            if (i_out_valid && !i_out_stall) begin
                o_words_out++;
                seen.overloaded = i_overloaded;
                seen.high_mask  = i_high_mask;
                if (exp_count == 0) begin
                    if (o_mismatches < MAX_REPORTS)
                        $display("%0t: unexpected status word overloaded=%0b high_mask=%b",
                                 $realtime, seen.overloaded, seen.high_mask);
                    o_mismatches++;
                end else begin
                    want   = exp_mem[rd_ptr];
                    rd_ptr = rd_ptr + Q_AW'(1);
                    exp_count--;
                    if (want.overloaded != seen.overloaded ||
                        want.high_mask != seen.high_mask)
                        report_mismatch(want, seen);
                end
            end
        end
        o_pending = exp_count;
    end

endmodule

### tb/windowed_overload_hysteresis_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_overload_hysteresis_unit_tb
// Top of the testbench. It drives sample words and limit writes, and makes
// random idle bursts on both channels. The checker instance beside the block
// predicts and compares every status word. This module only gives the verdict.
// ----------------------------------------------------------------------------
module windowed_overload_hysteresis_unit_tb;
    import wohu_pkg::*;

    // Window lengths shared by the block and the checker.
    localparam int unsigned WIN          = 8;
    // Idle margin after the last predicted status word; it makes it safe to
    // assume the block is idle once nothing is outstanding.
    localparam int unsigned QUIET_CYCLES = 4;
    localparam int unsigned PHASE_WORDS  = 320;
    localparam int unsigned NUM_PHASES   = 6;
    localparam logic [SMP_W-1:0] SMP_MAX = '1;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [SMP_W-1:0]  i_cpu_sample;
    logic [SMP_W-1:0]  i_mem_sample;
    logic [SMP_W-1:0]  i_gpu_sample;
    logic [SMP_W-1:0]  i_gpum_sample;
    logic [CNT_W-1:0]  i_samples_valid;
    logic              o_valid;
    logic              i_stall;
    logic              o_overloaded;
    logic [3:0]        o_high_mask;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned words_in;
    int unsigned words_out;

    // Idle rates in percent for the sender and the receiver. Both are zero in
    // the last phase so that the run ends with back-to-back traffic.
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;

    // The limits last written, used to aim the samples at the thresholds.
    logic [SMP_W-1:0] up_lim [NMET];
    logic [SMP_W-1:0] lo_lim [NMET];

    always #5 i_clk = ~i_clk;

    windowed_overload_hysteresis_unit #(
        .CPU_WINDOW (WIN),
        .MEM_WINDOW (WIN),
        .GPU_WINDOW (WIN),
        .GPUM_WINDOW(WIN)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cpu_sample   (i_cpu_sample),
        .i_mem_sample   (i_mem_sample),
        .i_gpu_sample   (i_gpu_sample),
        .i_gpum_sample  (i_gpum_sample),
        .i_samples_valid(i_samples_valid),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_overloaded   (o_overloaded),
        .o_high_mask    (o_high_mask),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    wohu_checker #(
        .CPU_WINDOW (WIN),
        .MEM_WINDOW (WIN),
        .GPU_WINDOW (WIN),
        .GPUM_WINDOW(WIN)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_cpu_sample   (i_cpu_sample),
        .i_mem_sample   (i_mem_sample),
        .i_gpu_sample   (i_gpu_sample),
        .i_gpum_sample  (i_gpum_sample),
        .i_samples_valid(i_samples_valid),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_overloaded   (o_overloaded),
        .i_high_mask    (o_high_mask),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_words_in     (words_in),
        .o_words_out    (words_out)
    );

    // Receiver side: random stall bursts at the current rate. After a burst the
    // stall drops low before another burst can start.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 99) < stall_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Presents one sample word and returns at the edge where it is taken.
    // An optional idle burst comes first; valid stays high across back-to-back
    // words, so it is written only once per time step.
    task automatic send_word(input logic [SMP_W-1:0] cpu, input logic [SMP_W-1:0] mem,
                             input logic [SMP_W-1:0] gpu, input logic [SMP_W-1:0] gpum,
                             input logic [CNT_W-1:0] cnt);
        if ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_cpu_sample    <= cpu;
        i_mem_sample    <= mem;
        i_gpu_sample    <= gpu;
        i_gpum_sample   <= gpum;
        i_samples_valid <= cnt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Holds off the sender until every predicted status word has come out, then
    // waits out the quiet margin so the block can finish a word that causes none.
    task automatic drain_status();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // One APB write: a setup phase, then an access phase that completes on
    // pready, then the bus idles before the task returns. Junk in the bits above
    // the limit width is sometimes added; the block keeps only the low bits.
    task automatic program_limit(input logic [1:0] met, input logic sel,
                                 input logic [SMP_W-1:0] value);
        logic [DATA_W-1:0] junk;
        junk    = $urandom_range(0, 1) ? DATA_W'($urandom()) : '0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {met, sel, 2'b00};
        pwdata  <= {junk[DATA_W-1:SMP_W], value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == LIM_UPPER)
            up_lim[met] = value;
        else
            lo_lim[met] = value;
        @(posedge i_clk);
    endtask

    // Random traffic made of episodes. Most episodes are long enough to fill
    // a window: either a run of high samples on one metric (with the others
    // mixed) that should push the block into overload, or a run of low samples
    // on all metrics that should bring it back. Short noise episodes with
    // random counts, including failed fetches and counts above four, sit
    // between them.
    task automatic run_phase(input int unsigned n_words);
        int unsigned      done_cnt;
        int unsigned      len;
        int unsigned      kind;
        int unsigned      hot;
        logic [SMP_W-1:0] smp [NMET];
        logic [CNT_W-1:0] cnt;
        done_cnt = 0;
        while (done_cnt < n_words) begin
            kind = $urandom_range(0, 9);
            len  = (kind < 8) ? $urandom_range(WIN, WIN + 4) : $urandom_range(1, 6);
            hot  = $urandom_range(0, NMET - 1);
            for (int k = 0; k < len; k++) begin
                for (int m = 0; m < NMET; m++) begin
                    if (kind < 4)
                        smp[m] = (m == hot || $urandom_range(0, 1)) ?
                                 SMP_W'($urandom_range(up_lim[m], SMP_MAX)) :
                                 SMP_W'($urandom_range(0, SMP_MAX));
                    else if (kind < 8)
                        smp[m] = SMP_W'($urandom_range(0, lo_lim[m]));
                    else
                        smp[m] = SMP_W'($urandom_range(0, SMP_MAX));
                end
                if (kind < 8)
                    cnt = ($urandom_range(0, 15) == 0) ? CNT_W'($urandom_range(0, 7)) :
                                                         CNT_W'(NMET);
                else
                    cnt = CNT_W'($urandom_range(0, 7));
                send_word(smp[0], smp[1], smp[2], smp[3], cnt);
                done_cnt++;
            end
        end
    endtask

    // Generous fixed bound on the whole run.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [SMP_W-1:0] up;
        logic [SMP_W-1:0] lo;

        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_cpu_sample    <= '0;
        i_mem_sample    <= '0;
        i_gpu_sample    <= '0;
        i_gpum_sample   <= '0;
        i_samples_valid <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        for (int m = 0; m < NMET; m++) begin
            up_lim[m] = 10'd900;
            lo_lim[m] = 10'd700;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset limits (900 upper, 700 lower).
        gap_pct   = 20;
        stall_pct = 20;
        // Failed fetch with the largest sample values: the windows stay empty,
        // so nothing can be reported.
        send_word(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, 3'd0);
        // Partial ticks: only cpu, then cpu and memory. The gpu windows are
        // still empty, so the block must stay regular.
        send_word(10'd1000, 10'd0, 10'd0, 10'd0, 3'd1);
        send_word(10'd0, 10'd1000, 10'd0, 10'd0, 3'd2);
        // A count above four acts as four. All windows now hold a sample, and
        // memory, gpu and gpu memory are entirely high, while cpu is not.
        send_word(10'd1000, 10'd1000, 10'd1000, 10'd1000, 3'd7);
        // A failed fetch in overload still runs the check, but nothing is low.
        send_word(10'd0, 10'd0, 10'd0, 10'd0, 3'd0);
        // A full window of zeros brings the block back to regular.
        for (int k = 0; k < WIN; k++)
            send_word(10'd0, 10'd0, 10'd0, 10'd0, 3'd4);
        // Samples exactly at the upper limit count as high.
        for (int k = 0; k < WIN; k++)
            send_word(10'd900, 10'd900, 10'd900, 10'd900, 3'd5);
        // Samples exactly at the lower limit count as low.
        for (int k = 0; k < WIN; k++)
            send_word(10'd700, 10'd700, 10'd700, 10'd700, 3'd4);
        drain_status();

        // Random phases, each with new limits written while the block is idle.
        // The first settings are the extremes: every sample both high and low,
        // only the largest value high and only zero low, and the nominal range.
        // Next comes an inverted setting with the upper limit below the lower
        // one, then random ones.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            for (int m = 0; m < NMET; m++) begin
                case (ph)
                    0: begin
                        up = '0;
                        lo = SMP_MAX;
                    end
                    1: begin
                        up = SMP_MAX;
                        lo = '0;
                    end
                    2: begin
                        up = 10'd1000;
                        lo = '0;
                    end
                    3: begin
                        lo = SMP_W'($urandom_range(300, SMP_MAX));
                        up = SMP_W'($urandom_range(0, lo));
                    end
                    default: begin
                        up = SMP_W'($urandom_range(500, SMP_MAX));
                        lo = SMP_W'($urandom_range(0, up));
                    end
                endcase
                program_limit(m[1:0], LIM_UPPER, up);
                program_limit(m[1:0], LIM_LOWER, lo);
            end
            if (ph == NUM_PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(0, 40);
                stall_pct = $urandom_range(0, 40);
            end
            run_phase(PHASE_WORDS);
            drain_status();
        end

        $display("Run covered %0d sample words under %0d limit settings,",
                 words_in, NUM_PHASES + 1);
        $display("from reset and extreme limits to inverted and random ones; %0d words checked.",
                 words_out);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/wohu_pkg.sv
rtl/wohu_met.sv
rtl/wohu_obuf.sv
rtl/windowed_overload_hysteresis_unit.sv
rtl/wohu_chk.sv
tb/wohu_checker.sv
tb/windowed_overload_hysteresis_unit_tb.sv
